[sv/dhpt_pkg.sv]
// shared constants and types of the double-hashed page table
// no dependencies
package dhpt_pkg;
    localparam int MAX_SLOTS      = 64;
    localparam int SLOT_W         = $clog2(MAX_SLOTS);
    localparam int MAX_PAGE_WORDS = 64;
    localparam int WORD_W         = $clog2(MAX_PAGE_WORDS);
    localparam int DATA_WIDTH     = 32;
    localparam int PID_W          = 31;
    localparam int CNT_W          = 7;
    localparam int PAGE_ADDR_W    = SLOT_W + WORD_W;
    localparam int PAGE_DEPTH     = MAX_SLOTS * MAX_PAGE_WORDS;
    localparam int ENTRY_W        = PID_W + SLOT_W;

    typedef enum logic [2:0] {
        MODE_INSERT = 3'd0,
        MODE_LOOKUP = 3'd1,
        MODE_WRITE  = 3'd2,
        MODE_READ   = 3'd3,
        MODE_DELETE = 3'd4
    } mode_t;

    typedef enum logic [0:0] {
        REG_SLOT_COUNT  = 1'b0,
        REG_PAGE_LENGTH = 1'b1
    } reg_idx_t;
endpackage

[sv/dhpt_ram.sv]
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module dhpt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[sv/dhpt_div.sv]
// restoring divider, one quotient bit per cycle, pid-wide dividend by slot count
// depends on dhpt_pkg
module dhpt_div
    import dhpt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [PID_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic             done,
    output logic [PID_W-1:0] quotient,
    output logic [CNT_W-1:0] remainder
);
    logic             run_reg;
    logic [4:0]       cnt_reg;
    logic [PID_W-1:0] quo_reg;
    logic [CNT_W-1:0] rem_reg;
    logic [CNT_W-1:0] dvs_reg;
    logic             done_reg;
    logic [CNT_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, quo_reg[PID_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= 5'(PID_W - 1);
                quo_reg <= dividend;
                rem_reg <= '0;
                dvs_reg <= divisor;
            end
            else if (run_reg)
            begin
                quo_reg <= {quo_reg[PID_W-2:0], fits};
                rem_reg <= fits ? CNT_W'(trial - {1'b0, dvs_reg}) : trial[CNT_W-1:0];
                if (cnt_reg == '0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 5'd1;
                end
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;
endmodule

[sv/double_hash_page_table.sv]
// a zero pid or unknown mode fails straight from idle; otherwise two hash divisions run
// one after another, then slots are probed, each through a registered slot ram read, and an
// insert goes on to scan downward over up to slot_count pages for a free one
// one operation at a time: busy is high until done; a zero pid or bad mode never raises it
// reset: clearing pass over all 4096 page store words with busy high; cfg writes still taken
// results appear for one cycle on done and cannot be stalled
module double_hash_page_table
    import dhpt_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         start,
    output logic                         busy,
    input  logic [2:0]                   mode,
    input  logic [PID_W-1:0]             pid,
    input  logic [WORD_W-1:0]            word_addr,
    input  logic signed [DATA_WIDTH-1:0] write_data,
    output logic                         done,
    output logic                         ok,
    output logic [SLOT_W-1:0]            slot_index,
    output logic signed [DATA_WIDTH-1:0] read_data
);
    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DIV1, S_DIV2, S_PROBE_RD, S_PROBE_CHK,
        S_ACT, S_SCAN, S_READ
    } state_t;

    state_t                 state_reg;
    logic [CNT_W-1:0]       slot_count_reg, page_length_reg;
    logic [CNT_W-1:0]       n_eff, len_eff;
    logic [2:0]             mode_reg;
    logic [PID_W-1:0]       pid_reg;
    logic [WORD_W-1:0]      addr_reg;
    logic [DATA_WIDTH-1:0]  wdata_reg;
    logic [CNT_W-1:0]       n_reg;
    logic [SLOT_W-1:0]      start_reg, step_reg, h_reg, j_reg;
    logic [CNT_W-1:0]       k_reg, used_reg;
    logic                   found_reg, empty_found_reg;
    logic [SLOT_W-1:0]      slot_reg, empty_slot_reg, page_reg;
    logic [MAX_SLOTS-1:0]   valid_reg, pbusy_reg;
    logic [PAGE_ADDR_W-1:0] clr_reg;
    logic                   done_reg, ok_reg;
    logic [SLOT_W-1:0]      slot_out_reg;
    logic [DATA_WIDTH-1:0]  rdata_reg;

    logic                   div_start, div_done;
    logic [PID_W-1:0]       div_dividend, div_quo;
    logic [CNT_W-1:0]       div_rem;
    logic                   slot_we;
    logic [SLOT_W-1:0]      slot_waddr;
    logic [ENTRY_W-1:0]     slot_wdata, slot_rdata;
    logic                   pg_we;
    logic [PAGE_ADDR_W-1:0] pg_waddr, pg_raddr;
    logic [DATA_WIDTH-1:0]  pg_wdata, pg_rdata;
    logic [PID_W-1:0]       owner;
    logic [CNT_W-1:0]       h_sum, h_next_w, k_next, step_w;
    logic [SLOT_W-1:0]      h_next;
    logic                   cfg_wr, accept, simple_fail;

    assign n_eff   = (slot_count_reg == '0) ? CNT_W'(1)
                   : (slot_count_reg > CNT_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : slot_count_reg;
    assign len_eff = (page_length_reg == '0) ? CNT_W'(1)
                   : (page_length_reg > CNT_W'(MAX_PAGE_WORDS)) ? CNT_W'(MAX_PAGE_WORDS)
                   : page_length_reg;

    assign cfg_wr      = psel && penable && pwrite && pready;
    assign pready      = 1'b1;
    assign prdata      = {25'd0, (paddr[2] == REG_PAGE_LENGTH) ? page_length_reg : slot_count_reg};
    assign busy        = (state_reg != S_IDLE);
    assign accept      = start && !busy;
    assign simple_fail = (pid == '0) || (mode > MODE_DELETE);

    assign owner   = valid_reg[h_reg] ? slot_rdata[ENTRY_W-1:SLOT_W] : '0;
    assign h_sum   = {1'b0, h_reg} + {1'b0, step_reg};
    assign h_next_w = (h_sum >= n_reg) ? h_sum - n_reg : h_sum;
    assign h_next  = h_next_w[SLOT_W-1:0];
    assign k_next  = k_reg + CNT_W'(1);
    // step is forced odd, wrapping to zero when it lands on n
    assign step_w  = div_rem[0] ? div_rem : div_rem + CNT_W'(1);

    dhpt_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (n_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    dhpt_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_SLOTS)) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (h_reg),
        .rdata (slot_rdata)
    );

    dhpt_ram #(.WIDTH(DATA_WIDTH), .DEPTH(PAGE_DEPTH)) u_page_ram (
        .clk   (clk),
        .we    (pg_we),
        .waddr (pg_waddr),
        .wdata (pg_wdata),
        .raddr (pg_raddr),
        .rdata (pg_rdata)
    );

    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = pid_reg;
        slot_we      = 1'b0;
        slot_waddr   = empty_slot_reg;
        slot_wdata   = {pid_reg, j_reg};
        pg_we        = 1'b0;
        pg_waddr     = {page_reg, addr_reg};
        pg_wdata     = wdata_reg;
        pg_raddr     = {page_reg, addr_reg};
        case (state_reg)
            S_CLEAR:
            begin
                pg_we    = 1'b1;
                pg_waddr = clr_reg;
                pg_wdata = '0;
            end
            S_DIV1:
            begin
                div_start    = (k_reg == '0);
            end
            S_DIV2:
            begin
                div_start    = (k_reg == '0);
                div_dividend = div_quo;
            end
            S_ACT:
            begin
                pg_we = (mode_reg == MODE_WRITE) && found_reg
                        && ({1'b0, addr_reg} < len_eff);
            end
            S_SCAN:
            begin
                slot_we = !pbusy_reg[j_reg];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            slot_count_reg  <= CNT_W'(MAX_SLOTS);
            page_length_reg <= CNT_W'(MAX_PAGE_WORDS);
            clr_reg         <= '0;
            used_reg        <= '0;
            valid_reg       <= '0;
            pbusy_reg       <= '0;
            done_reg        <= 1'b0;
            ok_reg          <= 1'b0;
            slot_out_reg    <= '0;
            rdata_reg       <= '0;
            k_reg           <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_wr)
            begin
                if (paddr[2] == REG_SLOT_COUNT)
                    slot_count_reg <= pwdata[CNT_W-1:0];
                else
                    page_length_reg <= pwdata[CNT_W-1:0];
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + PAGE_ADDR_W'(1);
                    if (clr_reg == PAGE_ADDR_W'(PAGE_DEPTH - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (simple_fail)
                        begin
                            done_reg     <= 1'b1;
                            ok_reg       <= 1'b0;
                            slot_out_reg <= '0;
                            rdata_reg    <= '0;
                        end
                        else
                        begin
                            mode_reg        <= mode;
                            pid_reg         <= pid;
                            addr_reg        <= word_addr;
                            wdata_reg       <= write_data;
                            n_reg           <= n_eff;
                            k_reg           <= '0;
                            found_reg       <= 1'b0;
                            empty_found_reg <= 1'b0;
                            state_reg       <= S_DIV1;
                        end
                    end
                end
                S_DIV1:
                begin
                    // k marks that the divider was launched for this pass
                    if (div_done)
                    begin
                        start_reg <= div_rem[SLOT_W-1:0];
                        h_reg     <= div_rem[SLOT_W-1:0];
                        k_reg     <= '0;
                        state_reg <= S_DIV2;
                    end
                    else
                    begin
                        k_reg <= CNT_W'(1);
                    end
                end
                S_DIV2:
                begin
                    if (div_done)
                    begin
                        step_reg  <= (step_w == n_reg) ? '0 : step_w[SLOT_W-1:0];
                        k_reg     <= '0;
                        state_reg <= S_PROBE_RD;
                    end
                    else
                    begin
                        k_reg <= CNT_W'(1);
                    end
                end
                S_PROBE_RD:
                begin
                    state_reg <= S_PROBE_CHK;
                end
                S_PROBE_CHK:
                begin
                    if (owner == pid_reg)
                    begin
                        found_reg <= 1'b1;
                        slot_reg  <= h_reg;
                        page_reg  <= slot_rdata[SLOT_W-1:0];
                        state_reg <= S_ACT;
                    end
                    else
                    begin
                        if (owner == '0 && !empty_found_reg)
                        begin
                            empty_found_reg <= 1'b1;
                            empty_slot_reg  <= h_reg;
                        end
                        h_reg <= h_next;
                        k_reg <= k_next;
                        if (h_next == start_reg || k_next == n_reg)
                            state_reg <= S_ACT;
                        else
                            state_reg <= S_PROBE_RD;
                    end
                end
                S_ACT:
                begin
                    done_reg     <= 1'b1;
                    ok_reg       <= 1'b0;
                    slot_out_reg <= '0;
                    rdata_reg    <= '0;
                    state_reg    <= S_IDLE;
                    case (mode_reg)
                        MODE_INSERT:
                        begin
                            if (!found_reg && used_reg < n_reg && empty_found_reg)
                            begin
                                done_reg  <= 1'b0;
                                j_reg     <= SLOT_W'(n_reg - CNT_W'(1));
                                state_reg <= S_SCAN;
                            end
                        end
                        MODE_LOOKUP:
                        begin
                            ok_reg       <= found_reg;
                            slot_out_reg <= found_reg ? slot_reg : '0;
                        end
                        MODE_WRITE:
                        begin
                            if (found_reg && {1'b0, addr_reg} < len_eff)
                            begin
                                ok_reg       <= 1'b1;
                                slot_out_reg <= slot_reg;
                            end
                        end
                        MODE_READ:
                        begin
                            if (found_reg && {1'b0, addr_reg} < len_eff)
                            begin
                                done_reg  <= 1'b0;
                                state_reg <= S_READ;
                            end
                        end
                        MODE_DELETE:
                        begin
                            if (found_reg)
                            begin
                                ok_reg              <= 1'b1;
                                slot_out_reg        <= slot_reg;
                                pbusy_reg[page_reg] <= 1'b0;
                                valid_reg[slot_reg] <= 1'b0;
                                used_reg            <= used_reg - CNT_W'(1);
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                S_SCAN:
                begin
                    // highest free page below n, searched downward
                    if (!pbusy_reg[j_reg])
                    begin
                        pbusy_reg[j_reg]          <= 1'b1;
                        valid_reg[empty_slot_reg] <= 1'b1;
                        used_reg                  <= used_reg + CNT_W'(1);
                        done_reg                  <= 1'b1;
                        ok_reg                    <= 1'b1;
                        slot_out_reg              <= empty_slot_reg;
                        rdata_reg                 <= '0;
                        state_reg                 <= S_IDLE;
                    end
                    else if (j_reg == '0)
                    begin
                        done_reg     <= 1'b1;
                        ok_reg       <= 1'b0;
                        slot_out_reg <= '0;
                        rdata_reg    <= '0;
                        state_reg    <= S_IDLE;
                    end
                    else
                    begin
                        j_reg <= j_reg - SLOT_W'(1);
                    end
                end
                S_READ:
                begin
                    done_reg     <= 1'b1;
                    ok_reg       <= 1'b1;
                    slot_out_reg <= slot_reg;
                    rdata_reg    <= pg_rdata;
                    state_reg    <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done       = done_reg;
    assign ok         = ok_reg;
    assign slot_index = slot_out_reg;
    assign read_data  = rdata_reg;

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done strobe while busy");
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !ok) |-> (slot_index == '0 && read_data == '0))
        else $error("failed transfer carries nonzero fields");
    a_used_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(used_reg))
        else $error("occupied slot count out of step");
    a_busy_pages: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(pbusy_reg) == int'(used_reg))
        else $error("busy page count out of step");
`endif
endmodule
